FILE: hw/rtl/sva_pkg.sv
// sva_pkg: types, widths and constant tables shared by the signed vector angle block
// depends on nothing; imported by sva_isqrt, sva_cordic, signed_vector_angle and its testbench
`default_nettype none

package sva_pkg;

  // field widths
  localparam int CW = 16;           // vector component bits
  localparam int AW = 16;           // angle bits
  localparam int STEPS = 18;        // cordic iterations
  localparam int FRAC = 59;         // radian accumulator fraction bits
  localparam int SQRT_STEPS = 32;   // root bits of a 64-bit radicand
  localparam int NW = 42;           // normalized sine / cosine, signed
  localparam int NMW = 41;          // normalized magnitude, unsigned
  localparam int XW = 45;           // cordic x / y, signed
  localparam int QW = AW + 1;       // quotient bits before rounding

  typedef struct packed {
    logic                 func;
    logic signed [CW-1:0] ax;
    logic signed [CW-1:0] ay;
    logic signed [CW-1:0] az;
    logic signed [CW-1:0] bx;
    logic signed [CW-1:0] by;
    logic signed [CW-1:0] bz;
    logic signed [CW-1:0] vx;
    logic signed [CW-1:0] vy;
    logic signed [CW-1:0] vz;
  } sva_in_t;

  typedef struct packed {
    logic [AW-1:0] angle;
    logic          status;
  } sva_out_t;

  // sideband that rides along the square root pipeline
  typedef struct packed {
    logic               func;
    logic               degen;
    logic               neg;
    logic signed [32:0] cz;
    logic signed [33:0] dot;
  } sva_side_t;

  // flags that ride along the cordic pipeline
  typedef struct packed {
    logic degen;
    logic zero;
  } sva_flags_t;

  // restoring division, used only to build constants
  function automatic logic [63:0] udiv(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] r;
    logic [63:0] q;
    r = '0;
    q = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], num[b]};
      if (r >= {1'b0, den}) begin
        r = r - {1'b0, den};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // atan(1/n) in Q59 by its series with truncated terms
  function automatic logic signed [63:0] atan_recip(input logic [63:0] n);
    logic [63:0] p;
    logic [63:0] t;
    logic [63:0] k;
    logic [63:0] n2;
    logic signed [63:0] sum;
    logic neg;
    p = udiv(64'd1 << FRAC, n);
    sum = '0;
    k = 64'd1;
    n2 = n * n;
    neg = 1'b0;
    for (int it = 0; it < 64; it++) begin
      if (p != 64'd0) begin
        t = udiv(p, k);
        sum = neg ? sum - $signed(t) : sum + $signed(t);
        neg = !neg;
        p = udiv(p, n2);
        k = k + 64'd2;
      end
    end
    return sum;
  endfunction

  function automatic logic signed [63:0] pi4_q();
    return (atan_recip(64'd5) <<< 2) - atan_recip(64'd239);
  endfunction

  // atan(2^-i) in Q59
  function automatic logic signed [63:0] atan_pow2(input int i);
    logic signed [63:0] sum;
    logic [63:0] t;
    logic neg;
    sum = '0;
    neg = 1'b0;
    if (i == 0) begin
      sum = pi4_q();
    end else begin
      for (int k = 1; k * i <= FRAC; k += 2) begin
        t = udiv(64'd1 << (FRAC - k * i), 64'(k));
        sum = neg ? sum - $signed(t) : sum + $signed(t);
        neg = !neg;
      end
    end
    return sum;
  endfunction

  localparam logic signed [63:0] PI_Q = pi4_q() <<< 2;
  localparam logic signed [63:0] TWO_PI_Q = pi4_q() <<< 3;

endpackage

`default_nettype wire

FILE: hw/rtl/sva_isqrt.sv
// sva_isqrt: pipelined floor square root of a 64-bit radicand, one root bit per stage
// depends on sva_pkg for widths and the sideband struct
`default_nettype none

module sva_isqrt import sva_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        src_valid,
  input  sva_side_t   src,
  input  logic [63:0] radicand,
  output logic        dst_valid,
  output sva_side_t   dst,
  output logic [31:0] root
);

  logic        vld [0:SQRT_STEPS];
  sva_side_t   sd  [0:SQRT_STEPS];
  logic [63:0] rem [0:SQRT_STEPS];
  logic [63:0] res [0:SQRT_STEPS];

  // stage zero is the input
  assign vld[0] = src_valid;
  assign sd[0]  = src;
  assign rem[0] = radicand;
  assign res[0] = '0;

  for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_step
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * g);
    logic [63:0] trial;
    logic [63:0] rem_next;
    logic [63:0] res_next;

    // one compare and subtract per stage
    always_comb begin
      trial = res[g] + BIT;
      if (rem[g] >= trial) begin
        rem_next = rem[g] - trial;
        res_next = (res[g] >> 1) + BIT;
      end else begin
        rem_next = rem[g];
        res_next = res[g] >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g+1] <= 1'b0;
      end else begin
        vld[g+1] <= vld[g];
      end
    end

    always_ff @(posedge clk) begin
      sd[g+1]  <= sd[g];
      rem[g+1] <= rem_next;
      res[g+1] <= res_next;
    end
  end

  assign dst_valid = vld[SQRT_STEPS];
  assign dst       = sd[SQRT_STEPS];
  assign root      = res[SQRT_STEPS][31:0];

endmodule

`default_nettype wire

FILE: hw/rtl/sva_cordic.sv
// sva_cordic: vectoring cordic on normalized (sine, cosine), then division by 2*pi
// depends on sva_pkg for widths, flags struct and the arctangent constants
`default_nettype none

module sva_cordic import sva_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 src_valid,
  input  sva_flags_t           src,
  input  logic signed [NW-1:0] sine,
  input  logic signed [NW-1:0] cosine,
  output logic                 dst_valid,
  output sva_flags_t           dst,
  output logic [QW-1:0]        quot
);

  logic                 vld [0:STEPS];
  sva_flags_t           fl  [0:STEPS];
  logic signed [XW-1:0] x   [0:STEPS];
  logic signed [XW-1:0] y   [0:STEPS];
  logic signed [63:0]   z   [0:STEPS];

  // fold the left half plane onto the right one
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= src_valid;
    end
  end

  always_ff @(posedge clk) begin
    fl[0] <= src;
    if (cosine < 0) begin
      x[0] <= -XW'(cosine);
      y[0] <= -XW'(sine);
      z[0] <= PI_Q;
    end else begin
      x[0] <= XW'(cosine);
      y[0] <= XW'(sine);
      z[0] <= '0;
    end
  end

  // one rotation per stage
  for (genvar g = 0; g < STEPS; g++) begin : g_rot
    localparam logic signed [63:0] T = atan_pow2(g);
    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;

    assign dx = y[g] >>> g;
    assign dy = x[g] >>> g;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g+1] <= 1'b0;
      end else begin
        vld[g+1] <= vld[g];
      end
    end

    always_ff @(posedge clk) begin
      fl[g+1] <= fl[g];
      if (y[g] >= 0) begin
        x[g+1] <= x[g] + dx;
        y[g+1] <= y[g] - dy;
        z[g+1] <= z[g] + T;
      end else begin
        x[g+1] <= x[g] - dx;
        y[g+1] <= y[g] + dy;
        z[g+1] <= z[g] - T;
      end
    end
  end

  // wrap the angle into one turn
  logic               w_valid;
  sva_flags_t         w_fl;
  logic [62:0]        w_r;
  logic signed [63:0] z_lo;
  logic signed [63:0] z_in;

  always_comb begin
    z_lo = (z[STEPS] < 0) ? z[STEPS] + TWO_PI_Q : z[STEPS];
    z_in = (z_lo >= TWO_PI_Q) ? z_lo - TWO_PI_Q : z_lo;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      w_valid <= 1'b0;
    end else begin
      w_valid <= vld[STEPS];
    end
  end

  always_ff @(posedge clk) begin
    w_fl <= fl[STEPS];
    w_r  <= z_in[62:0];
  end

  // restoring division by 2*pi, one quotient bit per stage
  logic          dv  [0:QW];
  sva_flags_t    dfl [0:QW];
  logic [62:0]   dr  [0:QW];
  logic [QW-1:0] dq  [0:QW];

  assign dv[0]  = w_valid;
  assign dfl[0] = w_fl;
  assign dr[0]  = w_r;
  assign dq[0]  = '0;

  for (genvar g = 0; g < QW; g++) begin : g_div
    logic [63:0] sh;
    logic        ge;

    assign sh = {dr[g], 1'b0};
    assign ge = (sh >= 64'(TWO_PI_Q));

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[g+1] <= 1'b0;
      end else begin
        dv[g+1] <= dv[g];
      end
    end

    always_ff @(posedge clk) begin
      dfl[g+1] <= dfl[g];
      dr[g+1]  <= ge ? 63'(sh - 64'(TWO_PI_Q)) : sh[62:0];
      dq[g+1]  <= {dq[g][QW-2:0], ge};
    end
  end

  assign dst_valid = dv[QW];
  assign dst       = dfl[QW];
  assign quot      = dq[QW];

endmodule

`default_nettype wire

FILE: hw/rtl/signed_vector_angle.sv
// signed_vector_angle: top level, product and cross terms, normalization, output register
// depends on sva_pkg, sva_isqrt and sva_cordic
//
// Usage:
//   An item (cmd) is taken at a rising edge with start high and busy low. busy is
//   always low: the block is a fixed pipeline and takes one item in every cycle.
//   Each item gives one result on the result port, marked by done for exactly one
//   cycle, once the item has passed the whole chain below. Results leave in the
//   order items came in.
//   The chain: five stages of input register, products, cross terms and sums,
//   32 stages of the square root (one root bit each), two stages of sign and
//   magnitude, three normalizing shift stages, the cordic fold and 18 rotation
//   stages, one wrap stage, 17 stages of division by 2*pi (one quotient bit each)
//   and the output register.
//   A zero-length a or b gives status 1 and angle 0.
//   Synchronous reset clears every valid bit: items in flight are dropped and no
//   done follows. The receiver cannot stall; a result not taken in its cycle is gone.
`default_nettype none

module signed_vector_angle import sva_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  sva_in_t  cmd,
  output logic     done,
  output sva_out_t result
);

  assign busy = 1'b0;

  // input register
  logic    a_valid;
  sva_in_t a_cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= start;
    end
  end

  always_ff @(posedge clk) begin
    a_cmd <= cmd;
  end

  // planar items drop the z components
  logic signed [CW-1:0] az_m;
  logic signed [CW-1:0] bz_m;
  logic                 a_degen;

  assign az_m = a_cmd.func ? a_cmd.az : '0;
  assign bz_m = a_cmd.func ? a_cmd.bz : '0;
  assign a_degen = (a_cmd.ax == 0 && a_cmd.ay == 0 && az_m == 0) ||
                   (a_cmd.bx == 0 && a_cmd.by == 0 && bz_m == 0);

  // products
  logic                 b_valid;
  logic                 b_func;
  logic                 b_degen;
  logic signed [31:0]   b_aybz, b_azby, b_azbx, b_axbz, b_axby, b_aybx;
  logic signed [31:0]   b_axbx, b_ayby, b_azbz;
  logic signed [CW-1:0] b_vx, b_vy, b_vz;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    b_func  <= a_cmd.func;
    b_degen <= a_degen;
    b_aybz  <= 32'(a_cmd.ay) * 32'(bz_m);
    b_azby  <= 32'(az_m) * 32'(a_cmd.by);
    b_azbx  <= 32'(az_m) * 32'(a_cmd.bx);
    b_axbz  <= 32'(a_cmd.ax) * 32'(bz_m);
    b_axby  <= 32'(a_cmd.ax) * 32'(a_cmd.by);
    b_aybx  <= 32'(a_cmd.ay) * 32'(a_cmd.bx);
    b_axbx  <= 32'(a_cmd.ax) * 32'(a_cmd.bx);
    b_ayby  <= 32'(a_cmd.ay) * 32'(a_cmd.by);
    b_azbz  <= 32'(az_m) * 32'(bz_m);
    b_vx    <= a_cmd.vx;
    b_vy    <= a_cmd.vy;
    b_vz    <= a_cmd.vz;
  end

  // cross vector and dot product
  logic                 c_valid;
  logic                 c_func;
  logic                 c_degen;
  logic signed [32:0]   c_cx, c_cy, c_cz;
  logic signed [33:0]   c_dot;
  logic signed [CW-1:0] c_vx, c_vy, c_vz;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else begin
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    c_func  <= b_func;
    c_degen <= b_degen;
    c_cx    <= 33'(b_aybz) - 33'(b_azby);
    c_cy    <= 33'(b_azbx) - 33'(b_axbz);
    c_cz    <= 33'(b_axby) - 33'(b_aybx);
    c_dot   <= 34'(b_axbx) + 34'(b_ayby) + 34'(b_azbz);
    c_vx    <= b_vx;
    c_vy    <= b_vy;
    c_vz    <= b_vz;
  end

  // squares of the cross terms and products with the view vector
  logic [31:0] mx, my, mz;
  logic [32:0] nx, ny, nz;

  assign nx = c_cx[32] ? 33'(-c_cx) : 33'(c_cx);
  assign ny = c_cy[32] ? 33'(-c_cy) : 33'(c_cy);
  assign nz = c_cz[32] ? 33'(-c_cz) : 33'(c_cz);
  assign mx = nx[31:0];
  assign my = ny[31:0];
  assign mz = nz[31:0];

  logic               d_valid;
  logic               d_func;
  logic               d_degen;
  logic [63:0]        d_sqx, d_sqy, d_sqz;
  logic signed [48:0] d_pvx, d_pvy, d_pvz;
  logic signed [32:0] d_cz;
  logic signed [33:0] d_dot;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else begin
      d_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    d_func  <= c_func;
    d_degen <= c_degen;
    d_sqx   <= 64'(mx) * 64'(mx);
    d_sqy   <= 64'(my) * 64'(my);
    d_sqz   <= 64'(mz) * 64'(mz);
    d_pvx   <= 49'(c_cx) * 49'(c_vx);
    d_pvy   <= 49'(c_cy) * 49'(c_vy);
    d_pvz   <= 49'(c_cz) * 49'(c_vz);
    d_cz    <= c_cz;
    d_dot   <= c_dot;
  end

  // squared length and view test
  logic signed [50:0] dv_sum;
  logic               e_valid;
  sva_side_t          e_side;
  logic [63:0]        e_sq;

  assign dv_sum = 51'(d_pvx) + 51'(d_pvy) + 51'(d_pvz);

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else begin
      e_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    e_side.func  <= d_func;
    e_side.degen <= d_degen;
    e_side.neg   <= dv_sum[50];
    e_side.cz    <= d_cz;
    e_side.dot   <= d_dot;
    e_sq         <= d_sqx + d_sqy + d_sqz;
  end

  // length of the cross vector
  logic        r_valid;
  sva_side_t   r_side;
  logic [31:0] r_root;

  sva_isqrt u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .src_valid (e_valid),
    .src       (e_side),
    .radicand  (e_sq),
    .dst_valid (r_valid),
    .dst       (r_side),
    .root      (r_root)
  );

  // pick the sine and give it its sign
  logic signed [33:0] root_s;
  logic               f_valid;
  logic               f_degen;
  logic signed [33:0] f_s;
  logic signed [33:0] f_c;

  assign root_s = $signed({2'b00, r_root});

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else begin
      f_valid <= r_valid;
    end
  end

  always_ff @(posedge clk) begin
    f_degen <= r_side.degen;
    f_c     <= r_side.dot;
    if (r_side.func) begin
      f_s <= r_side.neg ? -root_s : root_s;
    end else begin
      f_s <= 34'(r_side.cz);
    end
  end

  // larger magnitude of sine and cosine
  logic [33:0] abs_s;
  logic [33:0] abs_c;
  logic [32:0] max_sc;

  assign abs_s  = f_s[33] ? 34'(-f_s) : 34'(f_s);
  assign abs_c  = f_c[33] ? 34'(-f_c) : 34'(f_c);
  assign max_sc = (abs_s > abs_c) ? abs_s[32:0] : abs_c[32:0];

  logic                  n_valid [0:3];
  sva_flags_t            n_fl    [0:3];
  logic signed [NW-1:0]  n_s     [0:3];
  logic signed [NW-1:0]  n_c     [0:3];
  logic [NMW-1:0]        n_m     [0:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      n_valid[0] <= 1'b0;
    end else begin
      n_valid[0] <= f_valid;
    end
  end

  always_ff @(posedge clk) begin
    n_fl[0].degen <= f_degen;
    n_fl[0].zero  <= (max_sc == 0);
    n_s[0]        <= NW'(f_s);
    n_c[0]        <= NW'(f_c);
    n_m[0]        <= NMW'(max_sc);
  end

  // shift left until the larger magnitude reaches bit 40, two steps per stage
  for (genvar st = 0; st < 3; st++) begin : g_norm
    logic signed [NW-1:0] ts;
    logic signed [NW-1:0] tc;
    logic [NMW-1:0]       tm;

    always_comb begin
      ts = n_s[st];
      tc = n_c[st];
      tm = n_m[st];
      for (int j = 0; j < 2; j++) begin
        if (tm < (NMW'(1) << (NMW - (1 << (5 - 2 * st - j))))) begin
          tm = tm << (1 << (5 - 2 * st - j));
          ts = ts <<< (1 << (5 - 2 * st - j));
          tc = tc <<< (1 << (5 - 2 * st - j));
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        n_valid[st+1] <= 1'b0;
      end else begin
        n_valid[st+1] <= n_valid[st];
      end
    end

    always_ff @(posedge clk) begin
      n_fl[st+1] <= n_fl[st];
      n_s[st+1]  <= ts;
      n_c[st+1]  <= tc;
      n_m[st+1]  <= tm;
    end
  end

  // arctangent and conversion to turns
  logic          q_valid;
  sva_flags_t    q_fl;
  logic [QW-1:0] q_quot;

  sva_cordic u_cordic (
    .clk       (clk),
    .rst       (rst),
    .src_valid (n_valid[3]),
    .src       (n_fl[3]),
    .sine      (n_s[3]),
    .cosine    (n_c[3]),
    .dst_valid (q_valid),
    .dst       (q_fl),
    .quot      (q_quot)
  );

  // round half up, wrap a full turn, output register
  logic [QW:0] q_round;

  assign q_round = {1'b0, q_quot} + (QW+1)'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    result.status <= q_fl.degen;
    result.angle  <= (q_fl.degen || q_fl.zero) ? '0 : q_round[AW:1];
  end

endmodule

`default_nettype wire

FILE: tb/signed_vector_angle_tb.sv
// signed_vector_angle_tb: random and directed check of the vector angle block
// depends on sva_pkg and signed_vector_angle; predicts each angle in 64-bit integer math
`default_nettype none

module signed_vector_angle_tb import sva_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 80;
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic done;
  sva_in_t cmd = '0;
  sva_out_t result;

  sva_in_t pending_items[$];
  sva_out_t expected_angles[$];
  int mismatches = 0;
  int cycles = 0;
  bit feeding = 1'b0;

  signed_vector_angle u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .cmd(cmd), .done(done), .result(result)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // magnitude of a signed 64-bit value
  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    return v < 0 ? -v : v;
  endfunction

  function automatic logic [63:0] root64(input logic [63:0] n);
    logic [63:0] res;
    logic [63:0] bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic longint arctan_inv(input longint n);
    longint p, sum, k, n2;
    bit neg;
    p = (64'sd1 <<< 59) / n;
    sum = 0;
    k = 1;
    n2 = n * n;
    neg = 0;
    while (p > 0) begin
      sum = neg ? sum - p / k : sum + p / k;
      neg = !neg;
      p = p / n2;
      k += 2;
    end
    return sum;
  endfunction

  function automatic longint arctan_shift(input int i, input longint quarter);
    longint sum;
    bit neg;
    sum = 0;
    neg = 0;
    if (i == 0) return quarter;
    for (int k = 1; k * i <= 59; k += 2) begin
      sum = neg ? sum - (64'sd1 <<< (59 - k * i)) / k : sum + (64'sd1 <<< (59 - k * i)) / k;
      neg = !neg;
    end
    return sum;
  endfunction

  // cordic vectoring atan2 mapped to a fraction of a full turn
  function automatic logic [AW-1:0] turn_of(input longint s, input longint c);
    longint quarter, half, full, x, y, z, dx, dy;
    logic [63:0] m, r, q;
    quarter = 4 * arctan_inv(5) - arctan_inv(239);
    half = 4 * quarter;
    full = 8 * quarter;
    m = mag64(s) > mag64(c) ? mag64(s) : mag64(c);
    if (m == 0) return '0;
    while (m < (64'd1 << 40)) begin
      m = m << 1;
      s = s * 2;
      c = c * 2;
    end
    if (c < 0) begin
      x = -c; y = -s; z = half;
    end else begin
      x = c; y = s; z = 0;
    end
    for (int i = 0; i < STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += arctan_shift(i, quarter);
      end else begin
        x -= dx; y += dy; z -= arctan_shift(i, quarter);
      end
    end
    if (z < 0) z += full;
    if (z >= full) z -= full;
    r = z;
    q = 0;
    for (int i = 0; i < AW + 1; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= full) begin
        r = r - full;
        q[0] = 1'b1;
      end
    end
    return AW'((q + 1) >> 1);
  endfunction

  function automatic sva_out_t predict_angle(input sva_in_t it);
    sva_out_t o;
    longint ax, ay, az, bx, by, bz, cx, cy, cz, s, c, dv;
    ax = it.ax; ay = it.ay; bx = it.bx; by = it.by;
    az = it.func ? longint'(it.az) : 0;
    bz = it.func ? longint'(it.bz) : 0;
    o = '0;
    if ((ax == 0 && ay == 0 && az == 0) || (bx == 0 && by == 0 && bz == 0)) begin
      o.status = 1'b1;
      return o;
    end
    cx = ay * bz - az * by;
    cy = az * bx - ax * bz;
    cz = ax * by - ay * bx;
    c = ax * bx + ay * by + az * bz;
    if (!it.func) begin
      s = cz;
    end else begin
      s = root64(mag64(cx) * mag64(cx) + mag64(cy) * mag64(cy) + mag64(cz) * mag64(cz));
      dv = cx * longint'(it.vx) + cy * longint'(it.vy) + cz * longint'(it.vz);
      if (dv < 0) s = -s;
    end
    o.angle = turn_of(s, c);
    return o;
  endfunction

  // component biased toward extremes and small values
  function automatic logic [CW-1:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($urandom_range(0, 6)) - 16'd3;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic add_item(input int f, input int ax, input int ay, input int az,
                          input int bx, input int by, input int bz,
                          input int vx, input int vy, input int vz);
    sva_in_t it;
    it.func = 1'(f);
    it.ax = CW'(ax); it.ay = CW'(ay); it.az = CW'(az);
    it.bx = CW'(bx); it.by = CW'(by); it.bz = CW'(bz);
    it.vx = CW'(vx); it.vy = CW'(vy); it.vz = CW'(vz);
    pending_items.push_back(it);
  endtask

  // driver: bursts and gaps, changes on the falling edge
  int burst_left = 0;
  int gap_left = 0;
  always @(negedge clk) begin
    if (rst || !feeding || pending_items.size() == 0) begin
      start <= 1'b0;
    end else if (gap_left > 0) begin
      gap_left <= gap_left - 1;
      start <= 1'b0;
    end else begin
      cmd <= pending_items.pop_front();
      start <= 1'b1;
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 40);
        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
      end else begin
        burst_left <= burst_left - 1;
      end
    end
  end

  // monitor: accepted items and results at the rising edge
  always @(posedge clk) begin
    sva_out_t exp_r;
    cycles <= cycles + 1;
    if (!rst && start && !busy) expected_angles.push_back(predict_angle(cmd));
    if (!rst && done) begin
      if (expected_angles.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected result angle=%0d status=%0d",
                                      result.angle, result.status);
      end else begin
        exp_r = expected_angles.pop_front();
        if (exp_r.angle !== result.angle || exp_r.status !== result.status) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("mismatch: expected angle=%0d status=%0d, got angle=%0d status=%0d",
                     exp_r.angle, exp_r.status, result.angle, result.status);
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    // directed items: degenerate, parallel, antiparallel, extremes, view signs
    add_item(0, 0, 0, 5, 1, 2, 3, 0, 0, 0);
    add_item(0, 1, 2, 0, 0, 0, 7, 0, 0, 0);
    add_item(1, 0, 0, 0, 1, 1, 1, 1, 1, 1);
    add_item(1, 1, 1, 1, 0, 0, 0, 1, 1, 1);
    add_item(1, 0, 0, 9, 0, 0, 4, 0, 0, 1);
    add_item(0, 1, 0, 0, 1, 0, 0, 0, 0, 0);
    add_item(0, 1, 0, 0, -1, 0, 0, 0, 0, 0);
    add_item(0, 1, 0, 0, 0, 1, 0, 0, 0, 0);
    add_item(0, 1, 0, 0, 0, -1, 0, 0, 0, 0);
    add_item(0, 1, 0, 0, 1, -1, 0, 0, 0, 0);
    add_item(0, -32768, -32768, 0, 32767, 32767, 0, 0, 0, 0);
    add_item(0, -32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768);
    add_item(0, 32767, -32768, 0, -32768, 32767, 0, 0, 0, 0);
    add_item(1, -32768, -32768, -32768, 32767, 32767, 32767, 1, 1, 1);
    add_item(1, 1, 0, 0, 0, 1, 0, 0, 0, 1);
    add_item(1, 1, 0, 0, 0, 1, 0, 0, 0, -1);
    add_item(1, 1, 0, 0, 0, 1, 0, 0, 0, 0);
    add_item(1, 1, 0, 0, 0, 1, 0, 1, 1, 0);
    add_item(1, -32768, 0, 0, 0, -32768, 32767, -32768, -32768, -32768);
    add_item(1, 32767, 32767, -32768, -32768, 32767, 32767, 32767, -32768, 32767);
    add_item(0, 65536 - 1, 0, 0, 1, -1, 0, 0, 0, 0);
    // random items, a few parallel or degenerate
    for (int n = 0; n < 1550; n++) begin
      sva_in_t it;
      it.func = 1'($urandom_range(0, 1));
      it.ax = rand_comp(); it.ay = rand_comp(); it.az = rand_comp();
      it.bx = rand_comp(); it.by = rand_comp(); it.bz = rand_comp();
      it.vx = rand_comp(); it.vy = rand_comp(); it.vz = rand_comp();
      case ($urandom_range(0, 9))
        0: begin
          it.bx = it.ax; it.by = it.ay; it.bz = it.az;
        end
        1: begin
          it.bx = -it.ax; it.by = -it.ay; it.bz = -it.az;
        end
        2: begin
          it.ax = '0; it.ay = '0;
        end
        default: ;
      endcase
      pending_items.push_back(it);
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    feeding = 1'b1;
    wait (pending_items.size() == 0);
    @(posedge clk);
    @(posedge clk);
    wait (expected_angles.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);
    if (mismatches == 0 && expected_angles.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

`default_nettype wire
